FILE: design/msgsp_pkg.sv
// msgsp_pkg: shared types and constants of the multistage shortest path block
// no dependencies; imported by multistage_graph_shortest_path

package msgsp_pkg;

    // longest path that can be emitted, and its position index width
    localparam int MAX_PATH = 16;
    localparam int POS_W    = 4;
    // width of an emitted vertex number
    localparam int PV_W     = 4;

    // register reset values
    localparam logic [4:0]  VERTEX_COUNT_RESET = 5'd16;
    localparam logic [4:0]  STAGE_COUNT_RESET  = 5'd2;
    localparam logic        DIRECTION_RESET    = 1'b0;
    localparam logic [15:0] INFINITY_RESET     = 16'd999;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] CFG_STAGE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_DIRECTION     = 2'd2;
    localparam logic [1:0] CFG_INFINITY_COST = 2'd3;

    // input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // direction codes
    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_WRITE,
        ST_TRACE_RD,
        ST_TRACE_WB,
        ST_EMIT
    } state_t;

endpackage

FILE: design/msgsp_ram.sv
// msgsp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the edge, cost and choice stores

module msgsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/multistage_graph_shortest_path.sv
// multistage_graph_shortest_path: edge store, dp sequencer, path trace and output word
// depends on msgsp_pkg and msgsp_ram
//
//   channel  handshake            payload
//   in       in_valid/in_ready    op, from_vertex, to_vertex, edge_cost
//   out      out_valid/out_ready  path_vertex, total_cost, no_path, last
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// after reset the edge store is cleared, one entry a cycle, 4**clog2(MAX_VERTICES)
// entries (256 by default), with in_ready low; cfg_ready is always high.
// an edge load writes one entry when load_ok holds. a run sets the start vertex, walks
// the rows with one edge-store read per candidate edge, traces the path back through
// the choice ram and sends stage_count words out.
// the output register holds a word while out_ready is low; the next item is taken
// once the final word of a run sits in the output register.

module multistage_graph_shortest_path #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [3:0]  from_vertex,
    input  logic [3:0]  to_vertex,
    input  logic [9:0]  edge_cost,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  path_vertex,
    output logic [15:0] total_cost,
    output logic        no_path,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import msgsp_pkg::*;

    localparam int VW         = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EAW        = 2 * VW;
    localparam int EDGE_DEPTH = 1 << EAW;

    // configuration registers
    logic [4:0]  vertex_count_reg;
    logic [4:0]  stage_count_reg;
    logic        direction_reg;
    logic [15:0] infinity_cost_reg;

    // sequencer state
    state_t          state_reg, state_next;
    logic [EAW-1:0]  clr_addr_reg, clr_addr_next;
    logic [VW-1:0]   row_reg, row_next;
    logic [VW-1:0]   col_reg, col_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [VW-1:0]   rd_src_reg;
    logic [15:0]     acc_cost_reg, acc_cost_next;
    logic [VW-1:0]   acc_choice_reg, acc_choice_next;
    logic            acc_valid_reg, acc_valid_next;
    logic [15:0]     total_reg, total_next;
    logic [POS_W-1:0] tr_pos_reg, tr_pos_next;
    logic [VW-1:0]   tr_prev_reg, tr_prev_next;
    logic [POS_W-1:0] tr_left_reg, tr_left_next;
    logic            miss_reg, miss_next;
    logic [POS_W-1:0] emit_pos_reg, emit_pos_next;
    logic [PV_W-1:0] path_reg [MAX_PATH];

    // output word
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      path_vertex_reg;
    logic [15:0]     total_cost_reg;
    logic            no_path_reg;
    logic            last_reg;
    logic            out_load;

    // ram ports
    logic            edge_we;
    logic [EAW-1:0]  edge_waddr, edge_raddr;
    logic [9:0]      edge_wdata, edge_rdata;
    logic            cost_we;
    logic [VW-1:0]   cost_waddr;
    logic [15:0]     cost_wdata, cost_rdata;
    logic            choice_we;
    logic [VW-1:0]   choice_waddr;
    logic [VW:0]     choice_wdata, choice_rdata;

    // derived values
    logic [VW-1:0]    sink_v;
    logic [4:0]       ns_c;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] trace_steps;
    logic             in_take;
    logic             load_ok;
    logic             row_last;
    logic             rows_done;
    logic [16:0]      sum;
    logic             take;
    logic [15:0]      acc_cost_upd;
    logic [VW-1:0]    acc_choice_upd;
    logic             acc_valid_upd;
    logic             path_we;
    logic [POS_W-1:0] path_waddr;
    logic [PV_W-1:0]  path_wdata;
    logic             path_init;

    // clamped vertex and stage counts
    always_comb
    begin
        if (vertex_count_reg < 5'd2)
        begin
            sink_v = VW'(1);
        end
        else if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
        begin
            sink_v = VW'(MAX_VERTICES - 1);
        end
        else
        begin
            sink_v = VW'(vertex_count_reg - 5'd1);
        end

        if (stage_count_reg < 5'd2)
        begin
            ns_c = 5'd2;
        end
        else if (32'(stage_count_reg) > 32'(MAX_PATH))
        begin
            ns_c = 5'(MAX_PATH);
        end
        else
        begin
            ns_c = stage_count_reg;
        end
    end

    assign last_pos    = POS_W'(ns_c - 5'd1);
    assign trace_steps = POS_W'(ns_c - 5'd2);

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign load_ok   = (from_vertex < to_vertex)
                       && (32'(to_vertex) < 32'(MAX_VERTICES));

    // row walk limits
    assign row_last  = (direction_reg == DIR_BACKWARD) ? (col_reg == '0)
                                                        : (col_reg == row_reg + VW'(1));
    assign rows_done = (direction_reg == DIR_BACKWARD) ? (row_reg == sink_v)
                                                        : (row_reg == '0);

    // relaxation of the candidate read in the previous cycle
    assign sum  = {1'b0, cost_rdata} + 17'(edge_rdata);
    assign take = rd_vld_reg && (edge_rdata != '0) && (sum < {1'b0, acc_cost_reg});
    assign acc_cost_upd   = take ? sum[15:0] : acc_cost_reg;
    assign acc_choice_upd = take ? rd_src_reg : acc_choice_reg;
    assign acc_valid_upd  = take ? 1'b1 : acc_valid_reg;

    // output register load
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == EAW'(EDGE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take && (op == OP_RUN))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (row_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!rows_done)
                begin
                    state_next = ST_READ;
                end
                else if (ns_c == 5'd2)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TRACE_RD;
                end
            end
            ST_TRACE_RD:
            begin
                state_next = ST_TRACE_WB;
            end
            ST_TRACE_WB:
            begin
                if (tr_left_reg == POS_W'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TRACE_RD;
                end
            end
            ST_EMIT:
            begin
                if (out_load && (emit_pos_reg == last_pos))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and register next values
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rd_vld_next     = 1'b0;
        acc_cost_next   = acc_cost_reg;
        acc_choice_next = acc_choice_reg;
        acc_valid_next  = acc_valid_reg;
        total_next      = total_reg;
        tr_pos_next     = tr_pos_reg;
        tr_prev_next    = tr_prev_reg;
        tr_left_next    = tr_left_reg;
        miss_next       = miss_reg;
        emit_pos_next   = emit_pos_reg;

        edge_we      = 1'b0;
        edge_waddr   = {VW'(from_vertex), VW'(to_vertex)};
        edge_wdata   = edge_cost;
        cost_we      = 1'b0;
        cost_waddr   = row_reg;
        cost_wdata   = acc_cost_upd;
        choice_we    = 1'b0;
        choice_waddr = row_reg;
        choice_wdata = {acc_valid_upd, acc_choice_upd};
        path_we      = 1'b0;
        path_init    = 1'b0;
        path_waddr   = tr_pos_reg;
        path_wdata   = PV_W'(choice_rdata[VW-1:0]);

        case (state_reg)
            ST_CLEAR:
            begin
                edge_we       = 1'b1;
                edge_waddr    = clr_addr_reg;
                edge_wdata    = '0;
                clr_addr_next = clr_addr_reg + EAW'(1);
            end
            ST_IDLE:
            begin
                edge_we = in_take && (op == OP_LOAD) && load_ok;
            end
            ST_INIT:
            begin
                // the start vertex gets cost zero and no choice
                cost_we      = 1'b1;
                choice_we    = 1'b1;
                cost_wdata   = '0;
                choice_wdata = '0;
                path_init    = 1'b1;
                miss_next    = 1'b0;
                emit_pos_next   = '0;
                acc_cost_next   = infinity_cost_reg;
                acc_choice_next = '0;
                acc_valid_next  = 1'b0;
                if (direction_reg == DIR_BACKWARD)
                begin
                    cost_waddr   = '0;
                    choice_waddr = '0;
                    row_next     = VW'(1);
                    col_next     = '0;
                end
                else
                begin
                    cost_waddr   = sink_v;
                    choice_waddr = sink_v;
                    row_next     = sink_v - VW'(1);
                    col_next     = sink_v;
                end
            end
            ST_READ:
            begin
                rd_vld_next     = 1'b1;
                acc_cost_next   = acc_cost_upd;
                acc_choice_next = acc_choice_upd;
                acc_valid_next  = acc_valid_upd;
                if (!row_last)
                begin
                    col_next = col_reg - VW'(1);
                end
            end
            ST_WRITE:
            begin
                // write back the finished row before the next row reads it
                cost_we         = 1'b1;
                choice_we       = 1'b1;
                acc_cost_next   = infinity_cost_reg;
                acc_choice_next = '0;
                acc_valid_next  = 1'b0;
                if (!rows_done)
                begin
                    if (direction_reg == DIR_BACKWARD)
                    begin
                        row_next = row_reg + VW'(1);
                        col_next = row_reg;
                    end
                    else
                    begin
                        row_next = row_reg - VW'(1);
                        col_next = sink_v;
                    end
                end
                else
                begin
                    total_next   = acc_cost_upd;
                    tr_left_next = trace_steps;
                    if (direction_reg == DIR_BACKWARD)
                    begin
                        tr_pos_next  = trace_steps;
                        tr_prev_next = sink_v;
                    end
                    else
                    begin
                        tr_pos_next  = POS_W'(1);
                        tr_prev_next = '0;
                    end
                end
            end
            ST_TRACE_RD:
            begin
            end
            ST_TRACE_WB:
            begin
                // follow the recorded choice, or mark the miss
                path_we      = 1'b1;
                tr_left_next = tr_left_reg - POS_W'(1);
                if (choice_rdata[VW])
                begin
                    tr_prev_next = choice_rdata[VW-1:0];
                end
                else
                begin
                    miss_next    = 1'b1;
                    path_wdata   = '0;
                    tr_prev_next = '0;
                end
                if (direction_reg == DIR_BACKWARD)
                begin
                    tr_pos_next = tr_pos_reg - POS_W'(1);
                end
                else
                begin
                    tr_pos_next = tr_pos_reg + POS_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_pos_next = emit_pos_reg + POS_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // output word handshake
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // edge ram address: forward reads row to column, backward column to row
    assign edge_raddr = (direction_reg == DIR_BACKWARD) ? {col_reg, row_reg}
                                                         : {row_reg, col_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            rd_vld_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            vertex_count_reg  <= VERTEX_COUNT_RESET;
            stage_count_reg   <= STAGE_COUNT_RESET;
            direction_reg     <= DIRECTION_RESET;
            infinity_cost_reg <= INFINITY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data[4:0];
                    CFG_STAGE_COUNT:   stage_count_reg   <= cfg_data[4:0];
                    CFG_DIRECTION:     direction_reg     <= cfg_data[0];
                    CFG_INFINITY_COST: infinity_cost_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // sequencer payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        rd_src_reg     <= col_reg;
        acc_cost_reg   <= acc_cost_next;
        acc_choice_reg <= acc_choice_next;
        acc_valid_reg  <= acc_valid_next;
        total_reg      <= total_next;
        tr_pos_reg     <= tr_pos_next;
        tr_prev_reg    <= tr_prev_next;
        tr_left_reg    <= tr_left_next;
        miss_reg       <= miss_next;
        emit_pos_reg   <= emit_pos_next;
    end

    // traced path, endpoints set at run start
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATH; i++)
        begin
            if (path_init && (i == 0))
            begin
                path_reg[i] <= '0;
            end
            else if (path_init && (POS_W'(i) == last_pos))
            begin
                path_reg[i] <= PV_W'(sink_v);
            end
            else if (path_we && (POS_W'(i) == path_waddr))
            begin
                path_reg[i] <= path_wdata;
            end
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            path_vertex_reg <= miss_reg ? '0 : path_reg[emit_pos_reg];
            total_cost_reg  <= total_reg;
            no_path_reg     <= miss_reg;
            last_reg        <= (emit_pos_reg == last_pos);
        end
    end

    assign out_valid   = out_valid_reg;
    assign path_vertex = path_vertex_reg;
    assign total_cost  = total_cost_reg;
    assign no_path     = no_path_reg;
    assign last        = last_reg;

    // edge cost store
    msgsp_ram #(
        .WIDTH (10),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // best cost per vertex
    msgsp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_VERTICES)
    ) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (col_reg),
        .rdata (cost_rdata)
    );

    // best choice per vertex, valid bit on top
    msgsp_ram #(
        .WIDTH (VW + 1),
        .DEPTH (MAX_VERTICES)
    ) u_choice_ram (
        .clk   (clk),
        .we    (choice_we),
        .waddr (choice_waddr),
        .wdata (choice_wdata),
        .raddr (tr_prev_reg),
        .rdata (choice_rdata)
    );

endmodule
